[sv/lpmf_pkg.sv]
`timescale 1ns / 1ps
package lpmf_pkg;

  localparam int KEY_W         = 16;
  localparam int LEN_W         = 16;
  localparam int KEY_RANGE_DEF = 65536;

  localparam logic MODE_PUSH  = 1'b0;
  localparam logic MODE_CLEAR = 1'b1;

  typedef struct packed {
    logic             mode;
    logic [KEY_W-1:0] key;
  } in_t;

  typedef struct packed {
    logic [LEN_W-1:0] chain_len;
    logic [LEN_W-1:0] best_len;
  } out_t;

  typedef struct packed {
    logic             strobe;
    logic             clear;
    logic [LEN_W-1:0] len;
  } seq_res_t;

endpackage

[sv/lpmf_ram.sv]
`timescale 1ns / 1ps
module lpmf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sv/lpmf_seq.sv]
`timescale 1ns / 1ps
module lpmf_seq #(
  parameter int KEY_RANGE = lpmf_pkg::KEY_RANGE_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  lpmf_pkg::in_t                cmd,
  output logic                         busy,
  output lpmf_pkg::seq_res_t           rslt,
  output logic                         we,
  output logic [$clog2(KEY_RANGE)-1:0] waddr,
  output logic [lpmf_pkg::LEN_W-1:0]   wdata,
  output logic [$clog2(KEY_RANGE)-1:0] raddr,
  input  logic [lpmf_pkg::LEN_W-1:0]   rdata
);
  import lpmf_pkg::*;

  localparam int AW = $clog2(KEY_RANGE);
  localparam int IW = ((AW > KEY_W) ? AW : KEY_W) + 1;

  localparam logic [1:0] S_CLR  = 2'd0;
  localparam logic [1:0] S_IDLE = 2'd1;
  localparam logic [1:0] S_QRY  = 2'd2;
  localparam logic [1:0] S_UPD  = 2'd3;

  localparam logic [IW-1:0] RANGE_W = IW'(KEY_RANGE);
  localparam logic [AW-1:0] LAST_A  = AW'(KEY_RANGE - 1);

  logic [1:0]       state;
  logic [AW-1:0]    ca;
  logic [IW-1:0]    i_idx;
  logic [IW-1:0]    k_idx;
  logic [AW-1:0]    wa;
  logic             pend;
  logic [LEN_W-1:0] acc;
  logic [KEY_W-1:0] key_q;
  logic             clr_item;

  logic [IW-1:0]    key_w;
  logic [IW-1:0]    i_dec;
  logic [LEN_W-1:0] cmp_max;
  logic [LEN_W-1:0] len_sat;

  assign key_w   = IW'(cmd.key);
  assign i_dec   = i_idx - IW'(1);
  // shared compare unit: running max in query, node max in update
  assign cmp_max = (rdata > acc) ? rdata : acc;
  assign len_sat = (acc == {LEN_W{1'b1}}) ? acc : acc + LEN_W'(1);
  assign busy    = (state != S_IDLE);

  always_comb begin
    we    = 1'b0;
    waddr = wa;
    wdata = cmp_max;
    raddr = i_dec[AW-1:0];
    unique case (state)
      S_CLR: begin
        we    = 1'b1;
        waddr = ca;
        wdata = '0;
      end
      S_UPD: begin
        we    = pend;
        raddr = k_idx[AW-1:0];
      end
      S_QRY, S_IDLE: begin
        we = 1'b0;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLR;
      ca          <= '0;
      clr_item    <= 1'b0;
      pend        <= 1'b0;
      rslt.strobe <= 1'b0;
    end else begin
      rslt.strobe <= 1'b0;
      unique case (state)
        S_CLR: begin
          ca <= ca + AW'(1);
          if (ca == LAST_A) begin
            state       <= S_IDLE;
            rslt.strobe <= clr_item;
            rslt.clear  <= 1'b1;
            rslt.len    <= '0;
            clr_item    <= 1'b0;
          end
        end
        S_IDLE: begin
          if (start) begin
            if (cmd.mode == MODE_CLEAR) begin
              state    <= S_CLR;
              ca       <= '0;
              clr_item <= 1'b1;
            end else begin
              state <= S_QRY;
              i_idx <= (key_w < RANGE_W) ? key_w : RANGE_W;
              key_q <= cmd.key;
              acc   <= '0;
              pend  <= 1'b0;
            end
          end
        end
        S_QRY: begin
          if (pend) begin
            acc <= cmp_max;
          end
          if (i_idx != '0) begin
            i_idx <= i_dec & i_idx;
            pend  <= 1'b1;
          end else begin
            pend <= 1'b0;
            if (!pend) begin
              acc   <= len_sat;
              k_idx <= IW'(key_q);
              state <= S_UPD;
            end
          end
        end
        S_UPD: begin
          if (k_idx < RANGE_W) begin
            wa    <= k_idx[AW-1:0];
            k_idx <= k_idx | (k_idx + IW'(1));
            pend  <= 1'b1;
          end else begin
            pend <= 1'b0;
            if (!pend) begin
              state       <= S_IDLE;
              rslt.strobe <= 1'b1;
              rslt.clear  <= 1'b0;
              rslt.len    <= acc;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_strobe_idle: assert property (@(posedge clk) disable iff (rst)
    rslt.strobe |-> state == S_IDLE)
    else $error("result strobe while sequencer still active");

  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    (state == S_UPD && pend && k_idx < RANGE_W) |-> wa != k_idx[AW-1:0])
    else $error("update walk reads the node it is writing");

  a_idle_no_write: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !we)
    else $error("tree written while idle");

  a_push_len: assert property (@(posedge clk) disable iff (rst)
    (rslt.strobe && !rslt.clear) |-> rslt.len != '0)
    else $error("push produced zero chain length");

endmodule

[sv/lis_prefix_max_fenwick.sv]
`timescale 1ns / 1ps
// Channel   Handshake        Word
// command   start / busy     cmd   (mode, key)
// result    done             res   (chain_len, best_len)
//
// A push keeps busy high while the prefix walk and the update walk each visit one
// tree node per cycle on the single read port of the tree RAM. done rises in the
// cycle after busy falls. After reset, and for each clear word, busy stays high
// while the tree RAM is zeroed one entry per cycle.
// done lasts one cycle; the receiver cannot stall it.
module lis_prefix_max_fenwick #(
  parameter int KEY_RANGE = lpmf_pkg::KEY_RANGE_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  lpmf_pkg::in_t  cmd,
  output logic           busy,
  output logic           done,
  output lpmf_pkg::out_t res
);
  import lpmf_pkg::*;

  localparam int AW = $clog2(KEY_RANGE);

  seq_res_t         rslt;
  logic             we;
  logic [AW-1:0]    waddr;
  logic [LEN_W-1:0] wdata;
  logic [AW-1:0]    raddr;
  logic [LEN_W-1:0] rdata;
  logic [LEN_W-1:0] best;
  logic [LEN_W-1:0] best_next;

  lpmf_seq #(.KEY_RANGE(KEY_RANGE)) u_seq (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .cmd   (cmd),
    .busy  (busy),
    .rslt  (rslt),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  lpmf_ram #(.WIDTH(LEN_W), .DEPTH(KEY_RANGE)) u_tree (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign best_next = rslt.clear ? '0 : ((rslt.len > best) ? rslt.len : best);

  always_ff @(posedge clk) begin
    if (rst) begin
      best <= '0;
      done <= 1'b0;
    end else begin
      done <= rslt.strobe;
      if (rslt.strobe) begin
        best          <= best_next;
        res.chain_len <= rslt.len;
        res.best_len  <= best_next;
      end
    end
  end

  a_best_covers: assert property (@(posedge clk) disable iff (rst)
    done |-> res.best_len >= res.chain_len)
    else $error("best length below chain length");

  a_clear_zero: assert property (@(posedge clk) disable iff (rst)
    (done && res.chain_len == '0) |-> res.best_len == '0)
    else $error("clear result carries nonzero best length");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted word did not raise busy");

endmodule

[verif/lpmf_checker.sv]
`timescale 1ns / 1ps
module lpmf_checker #(
  parameter int KEY_RANGE = lpmf_pkg::KEY_RANGE_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic           busy,
  input  lpmf_pkg::in_t  cmd,
  input  logic           done,
  input  lpmf_pkg::out_t res,
  output int             mismatches,
  output int             outstanding
);
  import lpmf_pkg::*;

  localparam int unsigned LEN_SAT = (1 << LEN_W) - 1;

  logic [LEN_W-1:0] node_len [KEY_RANGE];
  logic [LEN_W-1:0] best_len_q = '0;
  out_t             expected_q [$];
  int               err_cnt = 0;

  function automatic void wipe_tree();
    foreach (node_len[n]) node_len[n] = '0;
    best_len_q = '0;
  endfunction

  function automatic void queue_word(input out_t w);
    expected_q = {expected_q, w};
  endfunction

  function automatic out_t extend_chain(input logic [KEY_W-1:0] k);
    int unsigned limit;
    int unsigned idx;
    int unsigned top_len;
    int unsigned len;
    out_t        r;
    limit   = (k < KEY_RANGE) ? 32'(k) : KEY_RANGE;
    top_len = 0;
    idx     = limit;
    while (idx > 0) begin
      if (node_len[idx-1] > top_len) top_len = 32'(node_len[idx-1]);
      idx = (idx - 1) & idx;
    end
    len = (top_len >= LEN_SAT) ? LEN_SAT : top_len + 1;
    idx = 32'(k);
    while (idx < KEY_RANGE) begin
      if (node_len[idx] < len) node_len[idx] = len[LEN_W-1:0];
      idx = idx | (idx + 1);
    end
    if (len > best_len_q) best_len_q = len[LEN_W-1:0];
    r.chain_len = len[LEN_W-1:0];
    r.best_len  = best_len_q;
    return r;
  endfunction

  always @(posedge clk) begin
    out_t want;
    if (rst) begin
      wipe_tree();
      expected_q.delete();
    end else begin
      if (done) begin
        if (expected_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("%0t: result word with nothing expected: chain_len %0d best_len %0d",
                     $realtime, res.chain_len, res.best_len);
        end else begin
          want = expected_q.pop_front();
          if (res.chain_len !== want.chain_len || res.best_len !== want.best_len) begin
            err_cnt++;
            if (err_cnt <= 10)
              $display("%0t: mismatch: chain_len exp %0d got %0d, best_len exp %0d got %0d",
                       $realtime, want.chain_len, res.chain_len, want.best_len, res.best_len);
          end
        end
      end
      if (start && !busy) begin
        if (cmd.mode == MODE_CLEAR) begin
          wipe_tree();
          queue_word('0);
        end else begin
          queue_word(extend_chain(cmd.key));
        end
      end
    end
    mismatches  <= err_cnt;
    outstanding <= expected_q.size();
  end

endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps
module tb_top;
  import lpmf_pkg::*;

  localparam int KEY_RANGE   = KEY_RANGE_DEF;
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int PHASES      = 4;
  localparam int PHASE_WORDS = 145;

  logic clk   = 1'b0;
  logic rst   = 1'b1;
  logic start = 1'b0;
  in_t  cmd   = '0;
  logic busy;
  logic done;
  out_t res;

  int mismatches;
  int outstanding;
  int cycles     = 0;
  int burst_left = 0;

  int unsigned corner_keys [$] = '{0, 0, 65535, 1, 2, 65534, 32768, 32767, 16'h5555,
                                   16'hAAAA, 3, 4, 65535, 100, 65533};
  int unsigned boundary_keys [$] = '{0, 1, 2, 32767, 32768, 65533, 65534, 65535};

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL lis_prefix_max_fenwick");
      $finish;
    end
  end

  lis_prefix_max_fenwick #(
    .KEY_RANGE(KEY_RANGE)
  ) u_top (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .cmd  (cmd),
    .busy (busy),
    .done (done),
    .res  (res)
  );

  lpmf_checker #(
    .KEY_RANGE(KEY_RANGE)
  ) u_checker (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .cmd        (cmd),
    .done       (done),
    .res        (res),
    .mismatches (mismatches),
    .outstanding(outstanding)
  );

  function automatic in_t push_word(input int unsigned k);
    in_t w;
    w.mode = MODE_PUSH;
    w.key  = k[KEY_W-1:0];
    return w;
  endfunction

  function automatic in_t clear_word();
    in_t w;
    w.mode = MODE_CLEAR;
    w.key  = KEY_W'($urandom_range(0, 65535));
    return w;
  endfunction

  function automatic in_t noise_word();
    in_t w;
    w.mode = 1'($urandom_range(0, 1));
    w.key  = KEY_W'($urandom_range(0, 65535));
    return w;
  endfunction

  task automatic send(input in_t w);
    int unsigned gap;
    start <= 1'b1;
    cmd   <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 50);
      if (gap > 0) begin
        start <= 1'b0;
        cmd   <= noise_word();
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // hold off until every word in flight has come back
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  initial begin
    int unsigned kind;
    int unsigned run;
    int unsigned k;
    int unsigned step;
    int          sent;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (corner_keys[i]) send(push_word(corner_keys[i]));
    drain();
    send(clear_word());
    send(push_word(65535));
    send(push_word(0));
    send(push_word(65535));

    for (int phase = 0; phase < PHASES; phase++) begin
      sent = 0;
      while (sent < PHASE_WORDS) begin
        kind = $urandom_range(0, 9);
        run  = $urandom_range(3, 20);
        if (kind <= 5) begin
          k = $urandom_range(0, 40000);
          repeat (run) begin
            send(push_word(k));
            step = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 1200);
            k = (k + step > 65535) ? 65535 : k + step;
            if ($urandom_range(0, 19) == 0) k = $urandom_range(0, k);
          end
        end else if (kind <= 7) begin
          repeat (run) send(push_word($urandom_range(0, 65535)));
        end else if (kind == 8) begin
          repeat (run) send(push_word($urandom_range(0, 15)));
        end else begin
          repeat (run)
            send(push_word(boundary_keys[$urandom_range(0, boundary_keys.size() - 1)]));
        end
        sent += run;
      end
      drain();
      if (phase < PHASES - 1) send(clear_word());
    end

    repeat (40) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("PASS lis_prefix_max_fenwick");
    end else begin
      $display("FAIL lis_prefix_max_fenwick");
    end
    $finish;
  end

endmodule

[lis_prefix_max_fenwick.f]
sv/lpmf_pkg.sv
sv/lpmf_ram.sv
sv/lpmf_seq.sv
sv/lis_prefix_max_fenwick.sv
verif/lpmf_checker.sv
verif/tb_top.sv
